// File: design/sac_pkg.sv
`timescale 1ns / 1ps
// Package for the swept box collision test: default word formats, axis codes
// and a width helper. Used by the top level and the divider.
package sac_pkg;
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CUBE_BITS     = 16;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction
endpackage

// File: design/sac_div.sv
`timescale 1ns / 1ps
// Pipelined signed fixed-point divider, one quotient bit per stage, with
// saturation and truncation toward zero. Depends on sac_pkg.
module sac_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int NUM_BITS  = 34
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [NUM_BITS-1:0]  num,
  input  logic signed [WORD_BITS-1:0] den,
  output logic signed [WORD_BITS-1:0] quo
);
  import sac_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int RW = imax(NUM_BITS + F, 2 * W - 1) + 1;

  logic [NUM_BITS-1:0] un0;
  logic [W-1:0]        ud0;
  logic                neg0;

  logic [RW-1:0] rem [W];
  logic [W-2:0]  q   [W];
  logic [W-1:0]  ud  [W];
  logic          neg [W];
  logic          sat [W];

  logic [W-2:0] mag;

  always_ff @(posedge clk) begin
    if (en) begin
      un0  <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
      ud0  <= den[W-1] ? W'(-den) : W'(den);
      neg0 <= num[NUM_BITS-1] ^ den[W-1];
      rem[0] <= RW'(un0) << F;
      q[0]   <= '0;
      ud[0]  <= ud0;
      neg[0] <= neg0;
      sat[0] <= RW'(un0) >= (RW'(ud0) << (W - 1 - F));
    end
  end

  for (genvar k = 0; k < W - 1; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(ud[k]) << (W - 2 - k);
    assign ge  = rem[k] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - dsh : rem[k];
        q[k+1]   <= {q[k][W-3:0], ge};
        ud[k+1]  <= ud[k];
        neg[k+1] <= neg[k];
        sat[k+1] <= sat[k];
      end
    end
  end

  assign mag = sat[W-1] ? '1 : q[W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end
endmodule

// File: design/swept_aabb_collision_test.sv
`timescale 1ns / 1ps
// Top level of the swept box against unit cube collision test.
// Depends on sac_pkg and sac_div.
//
// Channel  Direction  Fields
// s_axis   in         tdata: step xyz, mov_min xyz, mov_max xyz, cube xyz
// m_axis   out        tdata: contact_time, normal_x, normal_y, normal_z
//
// One test enters per cycle while the output is not stalled; the divider
// behind it resolves one quotient bit per stage.
// Reset clears only the valid bits of the pipeline.
// When the output transfer stalls, the whole pipeline holds.
module swept_aabb_collision_test #(
  parameter int WORD_BITS = sac_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = sac_pkg::DEF_FRAC_BITS,
  localparam int IN_BITS  = 9 * WORD_BITS + 3 * sac_pkg::CUBE_BITS,
  localparam int IN_TDATA = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = FRAC_BITS + 7,
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // step_x, step_y, step_z, mov_min_x/y/z, mov_max_x/y/z, cube_x/y/z
  input  logic [IN_TDATA-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // contact_time, normal_x, normal_y, normal_z
  output logic [OUT_TDATA-1:0] m_tdata
);
  import sac_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int CB   = CUBE_BITS;
  localparam int DW   = imax(CB + F + 1, W) + 1;
  localparam int DLAT = W + 2;

  localparam logic signed [W:0]   ONE  = (W + 1)'(1) << F;
  localparam logic signed [W-1:0] QMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W - 1){1'b0}}};

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [DW-1:0] a_edist [3];
  logic signed [DW-1:0] a_xdist [3];
  logic signed [W-1:0]  a_step  [3];
  logic [2:0]           a_zero;
  logic [2:0]           a_ele0;
  logic                 a_vld;

  for (genvar a = 0; a < 3; a++) begin : g_dist
    logic signed [W-1:0]  s, mn, mx;
    logic signed [CB-1:0] c;
    logic signed [DW-1:0] cmin, cmax, ed, xd;
    logic                 pos;
    assign s    = s_tdata[a*W +: W];
    assign mn   = s_tdata[(3 + a)*W +: W];
    assign mx   = s_tdata[(6 + a)*W +: W];
    assign c    = s_tdata[9*W + a*CB +: CB];
    assign cmin = DW'(c) <<< F;
    assign cmax = cmin + (DW'(1) << F);
    assign pos  = !s[W-1] && (s != '0);
    assign ed   = pos ? cmin - DW'(mx) : cmax - DW'(mn);
    assign xd   = pos ? cmax - DW'(mn) : cmin - DW'(mx);
    always_ff @(posedge clk) begin
      if (en) begin
        a_edist[a] <= ed;
        a_xdist[a] <= xd;
        a_step[a]  <= s;
        a_zero[a]  <= (s == '0);
        a_ele0[a]  <= ed[DW-1] || (ed == '0);
      end
    end
  end

  logic signed [W-1:0] d_ent [3];
  logic signed [W-1:0] d_ext [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    sac_div #(.WORD_BITS(W), .FRAC_BITS(F), .NUM_BITS(DW)) u_ent (
      .clk(clk), .en(en), .num(a_edist[a]), .den(a_step[a]), .quo(d_ent[a])
    );
    sac_div #(.WORD_BITS(W), .FRAC_BITS(F), .NUM_BITS(DW)) u_ext (
      .clk(clk), .en(en), .num(a_xdist[a]), .den(a_step[a]), .quo(d_ext[a])
    );
  end

  logic [2:0] zero_d [DLAT];
  logic [2:0] ele0_d [DLAT];
  logic [DLAT-1:0] vld_d;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_d[0] <= a_zero;
      ele0_d[0] <= a_ele0;
      for (int i = 1; i < DLAT; i++) begin
        zero_d[i] <= zero_d[i-1];
        ele0_d[i] <= ele0_d[i-1];
      end
    end
  end

  logic signed [W-1:0] p1_ent [3];
  logic signed [W-1:0] p1_ext [3];
  logic [2:0]          p1_ele0;
  logic                p1_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        p1_ent[a] <= zero_d[DLAT-1][a] ? QMIN : d_ent[a];
        p1_ext[a] <= zero_d[DLAT-1][a] ? QMAX : d_ext[a];
      end
      p1_ele0 <= ele0_d[DLAT-1];
    end
  end

  logic signed [W-1:0] t01, tin_c, x01, tout_c;
  logic [1:0]          comp_c;
  logic                gt10, gt21, gt20;

  always_comb begin
    gt10   = p1_ent[1] > p1_ent[0];
    gt21   = p1_ent[2] > p1_ent[1];
    gt20   = p1_ent[2] > p1_ent[0];
    t01    = gt10 ? p1_ent[1] : p1_ent[0];
    tin_c  = (p1_ent[2] > t01) ? p1_ent[2] : t01;
    x01    = (p1_ext[1] < p1_ext[0]) ? p1_ext[1] : p1_ext[0];
    tout_c = (p1_ext[2] < x01) ? p1_ext[2] : x01;
    if (gt10) begin
      comp_c = gt21 ? AXIS_Z : AXIS_Y;
    end else begin
      comp_c = gt20 ? AXIS_Z : AXIS_X;
    end
  end

  logic signed [W-1:0] p2_tin, p2_tout;
  logic [1:0]          p2_comp;
  logic                p2_ele0, p2_neg, p2_above, p2_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_tin   <= tin_c;
      p2_tout  <= tout_c;
      p2_comp  <= comp_c;
      p2_ele0  <= p1_ele0[comp_c];
      p2_neg   <= p1_ent[0][W-1] && p1_ent[1][W-1] && p1_ent[2][W-1];
      p2_above <= ((W + 1)'(p1_ent[0]) > ONE) || ((W + 1)'(p1_ent[1]) > ONE) ||
                  ((W + 1)'(p1_ent[2]) > ONE);
    end
  end

  logic                nohit;
  logic signed [1:0]   nsel;
  logic [F:0]          contact_time;
  logic signed [1:0]   normal_x, normal_y, normal_z;

  assign nohit = (p2_tin > p2_tout) || p2_neg || p2_above;
  assign nsel  = p2_ele0 ? NORM_POS : NORM_NEG;

  always_ff @(posedge clk) begin
    if (en) begin
      contact_time <= nohit ? ONE[F:0] : p2_tin[F:0];
      normal_x     <= (!nohit && p2_comp == AXIS_X) ? nsel : NORM_ZERO;
      normal_y     <= (!nohit && p2_comp == AXIS_Y) ? nsel : NORM_ZERO;
      normal_z     <= (!nohit && p2_comp == AXIS_Z) ? nsel : NORM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      vld_d    <= '0;
      p1_vld   <= 1'b0;
      p2_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      a_vld    <= s_tvalid;
      vld_d    <= {vld_d[DLAT-2:0], a_vld};
      p1_vld   <= vld_d[DLAT-1];
      p2_vld   <= p1_vld;
      m_tvalid <= p2_vld;
    end
  end

  assign m_tdata = OUT_TDATA'({normal_z, normal_y, normal_x, contact_time});

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({normal_x != NORM_ZERO, normal_y != NORM_ZERO,
                           normal_z != NORM_ZERO}))
    else $error("more than one normal axis set");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (contact_time <= ONE[F:0]))
    else $error("contact time above one");

  a_miss_time: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && normal_x == NORM_ZERO && normal_y == NORM_ZERO &&
     normal_z == NORM_ZERO) |-> (contact_time == ONE[F:0]))
    else $error("miss without full contact time");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(vld_d) && $stable(p2_vld)))
    else $error("pipeline moved during a stall");
endmodule
